FILE: hdl/pirsag_pkg.sv
// Package for the PIR sensitivity pulse and alarm gate.
// Holds the operation codes, register indexes, pulse phase codes and the
// sensitivity-to-pulse-extension table. Depends on nothing.
package pirsag_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned EXT_W     = 5;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = HOLD_W;

  // Operation codes carried by each request.
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_PROGRAM = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_OFF    = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [LEVEL_W-1:0] SENSITIVITY_RESET = 3'd3;
  localparam logic [HOLD_W-1:0]  HOLD_OFF_RESET    = 16'd10;

  // Programming pulse phases.
  localparam logic [PHASE_W-1:0] PH_HIGH_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOW_GAP     = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH_SECOND = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FINISH      = 2'd3;

  // Phase thresholds before the sensitivity extension is added.
  localparam logic [COUNT_W-1:0] FIRST_EDGE  = 6'd6;
  localparam logic [COUNT_W-1:0] SECOND_EDGE = 6'd12;

  // Pulse value of the level divided by five: 5, 35, 65, 80, 100 give
  // 1, 7, 13, 16, 20; every other level gives no extension.
  function automatic logic [EXT_W-1:0] pulse_ext(input logic [LEVEL_W-1:0] level);
    logic [EXT_W-1:0] ext;
    case (level)
      3'd1:    ext = 5'd1;
      3'd2:    ext = 5'd7;
      3'd3:    ext = 5'd13;
      3'd4:    ext = 5'd16;
      3'd5:    ext = 5'd20;
      default: ext = 5'd0;
    endcase
    return ext;
  endfunction

endpackage

FILE: hdl/pirsag_if.sv
// Channel interfaces for the PIR sensitivity pulse and alarm gate.
// pirsag_item_if carries requests in, pirsag_result_if carries results out.
// Depends on pirsag_pkg for the field widths.
interface pirsag_item_if;
  import pirsag_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic                pir_level;
  logic [TIME_W-1:0]   now_seconds;
  logic                motion_active;

  modport source (output valid, op, pir_level, now_seconds, motion_active, input ready);
  modport sink   (input valid, op, pir_level, now_seconds, motion_active, output ready);
endinterface

interface pirsag_result_if;
  logic valid;
  logic ready;
  logic pulse_level;
  logic programming;
  logic alarm_new;
  logic alarm_with_motion;
  logic pir_active;

  modport source (output valid, pulse_level, programming, alarm_new, alarm_with_motion,
                  pir_active, input ready);
  modport sink   (input valid, pulse_level, programming, alarm_new, alarm_with_motion,
                  pir_active, output ready);
endinterface

FILE: hdl/pir_sensitivity_pulse_and_alarm_gate_core.sv
// Top level of the PIR sensitivity pulse and alarm gate.
// Depends on pirsag_pkg and the channel interfaces in pirsag_if.sv.
//
// Usage. Requests arrive on the item channel and carry an operation: a
// pulse tick advances the four-phase programming pulse on the sensor pin
// while a programming request is pending, a sensor sample runs the alarm
// gate with its hold-off, and a programming request re-arms the pulse.
// Each request yields exactly one result on the result channel, which
// reports the pin level, the programming flag, the two alarm strobes and
// the PIR alarm status after that request.
// A request's result is registered and shows in the cycle after it is
// accepted. Throughput is one request per cycle while results are taken;
// the state update and the result are formed by a small lookup, a 6-bit
// count compare and one 32-bit subtract and compare in the accepting cycle.
// The result register parts the two sides: a new request is taken while
// the present result is being taken, and when the receiver stalls the
// result holds and the item channel stops accepting until it drains.
// Configuration writes (sensitivity level, hold-off seconds) take effect
// at the edge of the write; the user makes them only while the block is
// idle, which the block does not enforce. Reset clears the pulse sequence
// and alarm state, arms a programming request so that the sensor is
// programmed after start, and restores the defaults: level three, ten seconds.
module pir_sensitivity_pulse_and_alarm_gate_core (
  input  logic                                clk,
  input  logic                                rst,
  pirsag_item_if.sink                         item,
  pirsag_result_if.source                     result,
  input  logic                                cfg_we,
  input  logic [pirsag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pirsag_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pirsag_pkg::*;

  // Configuration registers.
  logic [LEVEL_W-1:0] sensitivity_level;
  logic [HOLD_W-1:0]  hold_off_seconds;

  // Pulse and alarm state.
  logic [PHASE_W-1:0] phase, phase_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic               request_pending, request_pending_next;
  logic               programming_flag, programming_flag_next;
  logic               pin_level, pin_level_next;
  logic [TIME_W-1:0]  last_alarm_time, last_alarm_time_next;
  logic               active_flag, active_flag_next;

  // Result register.
  logic               res_valid;
  logic               res_alarm_new, res_alarm_new_next;
  logic               res_alarm_motion, res_alarm_motion_next;

  logic               accept;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] ext;
  logic [TIME_W-1:0]  elapsed;
  logic               past_hold_off;
  logic               gate_open;

  // The result slot is free when empty or being taken in this cycle.
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign count_inc     = tick_count + COUNT_W'(1);
  assign ext           = COUNT_W'(pulse_ext(sensitivity_level));
  assign elapsed       = item.now_seconds - last_alarm_time;
  assign past_hold_off = elapsed > TIME_W'(hold_off_seconds);
  assign gate_open     = (sensitivity_level != '0) || request_pending || programming_flag;

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    request_pending_next  = request_pending;
    programming_flag_next = programming_flag;
    pin_level_next        = pin_level;
    last_alarm_time_next  = last_alarm_time;
    active_flag_next      = active_flag;
    res_alarm_new_next    = 1'b0;
    res_alarm_motion_next = 1'b0;
    case (item.op)
      OP_TICK: begin
        if (request_pending) begin
          programming_flag_next = 1'b1;
          tick_count_next       = count_inc;
          case (phase)
            PH_HIGH_FIRST: begin
              pin_level_next = 1'b1;
              if (count_inc > FIRST_EDGE) phase_next = PH_LOW_GAP;
            end
            PH_LOW_GAP: begin
              pin_level_next = 1'b0;
              if (count_inc > FIRST_EDGE + ext) phase_next = PH_HIGH_SECOND;
            end
            PH_HIGH_SECOND: begin
              pin_level_next = 1'b1;
              if (count_inc > SECOND_EDGE + ext) phase_next = PH_FINISH;
            end
            default: begin
              // Final phase: drop the pin and retire the request.
              pin_level_next        = 1'b0;
              tick_count_next       = '0;
              phase_next            = PH_HIGH_FIRST;
              request_pending_next  = 1'b0;
              programming_flag_next = 1'b0;
            end
          endcase
        end
      end
      OP_SAMPLE: begin
        if (gate_open && past_hold_off) begin
          if (item.pir_level) begin
            last_alarm_time_next  = item.now_seconds;
            active_flag_next      = 1'b1;
            res_alarm_motion_next = item.motion_active;
            res_alarm_new_next    = !item.motion_active;
          end else begin
            active_flag_next = 1'b0;
          end
        end
      end
      OP_PROGRAM: begin
        request_pending_next = 1'b1;
      end
      default: begin
        // Unused operation: state is left alone and reported as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_level <= SENSITIVITY_RESET;
      hold_off_seconds  <= HOLD_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSITIVITY: sensitivity_level <= cfg_data[LEVEL_W-1:0];
        REG_HOLD_OFF:    hold_off_seconds  <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HIGH_FIRST;
      tick_count       <= '0;
      request_pending  <= 1'b1;
      programming_flag <= 1'b0;
      pin_level        <= 1'b0;
      last_alarm_time  <= '0;
      active_flag      <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      request_pending  <= request_pending_next;
      programming_flag <= programming_flag_next;
      pin_level        <= pin_level_next;
      last_alarm_time  <= last_alarm_time_next;
      active_flag      <= active_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Alarm strobes are payload; the status fields read the state registers,
  // which change only when the next request is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_alarm_new    <= res_alarm_new_next;
      res_alarm_motion <= res_alarm_motion_next;
    end
  end

  assign result.valid             = res_valid;
  assign result.pulse_level       = pin_level;
  assign result.programming       = programming_flag;
  assign result.alarm_new         = res_alarm_new;
  assign result.alarm_with_motion = res_alarm_motion;
  assign result.pir_active        = active_flag;

  // The programming flag and any phase beyond the first need a pending request.
  assert property (@(posedge clk) disable iff (rst)
    (programming_flag || phase != PH_HIGH_FIRST) |-> request_pending)
    else $error("pulse sequence running without a pending request");

  // Each phase leaves once its threshold is passed, so the count stays small.
  assert property (@(posedge clk) disable iff (rst) tick_count <= 6'd34)
    else $error("pulse tick count ran past the last phase");

  // At most one kind of alarm is reported with a result.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_alarm_new && res_alarm_motion))
    else $error("both alarm strobes raised for one request");

  // An alarm reported on a fresh result recorded the sample's time.
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.op == OP_SAMPLE && item.pir_level && gate_open && past_hold_off)
      |=> (last_alarm_time == $past(item.now_seconds)) && active_flag
          && (res_alarm_new || res_alarm_motion))
    else $error("accepted alarm did not record its time");

  // A stalled result keeps the state it reports.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(active_flag) && $stable(pin_level))
    else $error("reported state changed while the result was stalled");

endmodule

FILE: bench/pir_sensitivity_pulse_and_alarm_gate_core_tb.sv
// Self-checking testbench for the PIR sensitivity pulse and alarm gate core.
// Needs pirsag_pkg, the channel interfaces of pirsag_if.sv and the core itself;
// it predicts every result with its own model of the block and checks it.
module pir_sensitivity_pulse_and_alarm_gate_core_tb;
  import pirsag_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The item field allows a fourth operation code that the block must treat
  // as a plain status read.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Length of the long receiver hold-off, and the settling pause that is
  // allowed after the last result before a register write or the end.
  localparam int STALL_CYCLES = 150;
  localparam int DRAIN_CYCLES = 3;

  // One result as the block reports it.
  typedef struct packed {
    logic pulse_level;
    logic programming;
    logic alarm_new;
    logic alarm_with_motion;
    logic pir_active;
  } sensor_status_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pirsag_item_if   item_ch ();
  pirsag_result_if result_ch ();

  pir_sensitivity_pulse_and_alarm_gate_core dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // Run limit: this only fires if the block hangs or loses a result.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction. The testbench keeps its own copy of the sensor controller:
  // the two configuration registers, the pulse sequencer and the alarm gate.
  // ---------------------------------------------------------------------
  logic [LEVEL_W-1:0] cfg_sensitivity;
  logic [HOLD_W-1:0]  cfg_hold_off;
  logic [PHASE_W-1:0] pulse_phase;
  logic [COUNT_W-1:0] pulse_ticks;
  logic               program_armed;
  logic               program_running;
  logic               pin_high;
  logic [TIME_W-1:0]  last_alarm_at;
  logic               alarm_latched;

  sensor_status_t awaited_status[$];
  int failures = 0;

  // Time stamp used to build realistic sample sequences.
  logic [TIME_W-1:0] wall_clock;

  task automatic reset_sensor_model();
    cfg_sensitivity = SENSITIVITY_RESET;
    cfg_hold_off    = HOLD_OFF_RESET;
    pulse_phase     = PH_HIGH_FIRST;
    pulse_ticks     = '0;
    program_armed   = 1'b1;
    program_running = 1'b0;
    pin_high        = 1'b0;
    last_alarm_at   = '0;
    alarm_latched   = 1'b0;
  endtask

  // The sensor datasheet gives pulse widths of 5, 35, 65, 80 and 100 for
  // levels one to five; the sequencer stretches its low gap by a fifth of that.
  function automatic int pulse_width_of(input logic [LEVEL_W-1:0] lvl);
    case (lvl)
      3'd1: return 5;
      3'd2: return 35;
      3'd3: return 65;
      3'd4: return 80;
      3'd5: return 100;
      default: return 0;
    endcase
  endfunction

  task automatic predict_sensor_status(input logic [OP_W-1:0] op, input logic level,
                                       input logic [TIME_W-1:0] now, input logic motion);
    sensor_status_t st;
    int stretch;
    logic [TIME_W-1:0] elapsed;
    st = '0;
    case (op)
      OP_TICK: begin
        if (program_armed) begin
          program_running = 1'b1;
          stretch = pulse_width_of(cfg_sensitivity) / 5;
          pulse_ticks = pulse_ticks + 1'b1;
          case (pulse_phase)
            PH_HIGH_FIRST: begin
              pin_high = 1'b1;
              if (int'(pulse_ticks) > int'(FIRST_EDGE)) pulse_phase = PH_LOW_GAP;
            end
            PH_LOW_GAP: begin
              pin_high = 1'b0;
              if (int'(pulse_ticks) > int'(FIRST_EDGE) + stretch) pulse_phase = PH_HIGH_SECOND;
            end
            PH_HIGH_SECOND: begin
              pin_high = 1'b1;
              if (int'(pulse_ticks) > int'(SECOND_EDGE) + stretch) pulse_phase = PH_FINISH;
            end
            default: begin
              pin_high        = 1'b0;
              pulse_ticks     = '0;
              pulse_phase     = PH_HIGH_FIRST;
              program_armed   = 1'b0;
              program_running = 1'b0;
            end
          endcase
        end
      end
      OP_SAMPLE: begin
        // The gate is dead only when the sensor is switched off and no
        // programming is pending or under way.
        if (cfg_sensitivity != '0 || program_armed || program_running) begin
          elapsed = now - last_alarm_at;
          if (level) begin
            if (elapsed > TIME_W'(cfg_hold_off)) begin
              last_alarm_at = now;
              alarm_latched = 1'b1;
              if (motion) st.alarm_with_motion = 1'b1;
              else st.alarm_new = 1'b1;
            end
          end else if (elapsed > TIME_W'(cfg_hold_off)) begin
            alarm_latched = 1'b0;
          end
        end
      end
      OP_PROGRAM: program_armed = 1'b1;
      default: ;
    endcase
    st.pulse_level = pin_high;
    st.programming = program_running;
    st.pir_active  = alarm_latched;
    awaited_status.push_back(st);
  endtask

  // Every request taken by the block is fed to the model at its accepting edge.
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      predict_sensor_status(item_ch.op, item_ch.pir_level, item_ch.now_seconds,
                            item_ch.motion_active);
    end
  end

  // ---------------------------------------------------------------------
  // Checking. Each result taken from the block is matched against the
  // oldest prediction, one field at a time.
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    sensor_status_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_status.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
      end else begin
        want = awaited_status.pop_front();
        check_field("pulse_level", want.pulse_level, result_ch.pulse_level);
        check_field("programming", want.programming, result_ch.programming);
        check_field("alarm_new", want.alarm_new, result_ch.alarm_new);
        check_field("alarm_with_motion", want.alarm_with_motion, result_ch.alarm_with_motion);
        check_field("pir_active", want.pir_active, result_ch.pir_active);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Ready is drawn at random each cycle, except during a long
  // hold-off which the back-pressure test asks for by bumping stall_asked.
  // The stretch itself is counted here, so the sender is free to keep
  // offering requests while the block fills up.
  // ---------------------------------------------------------------------
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_asked   = 0;
  int stall_granted = 0;
  int stall_left    = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_granted != stall_asked) begin
      result_ch.ready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_granted <= stall_asked;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers. All of them are entered and left just after a rising
  // edge, and drive the block with nonblocking assignments.
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input logic level,
                              input logic [TIME_W-1:0] now, input logic motion);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.op            <= op;
    item_ch.pir_level     <= level;
    item_ch.now_seconds   <= now;
    item_ch.motion_active <= motion;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops offering, waits for every predicted result to be taken, then lets
  // the DRAIN_CYCLES settling pause go by.
  task automatic wait_until_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SENSITIVITY) cfg_sensitivity = data[LEVEL_W-1:0];
    else cfg_hold_off = data;
  endtask

  // A random request. Samples mostly follow a plausible wall clock: runs of
  // closely spaced samples, gaps around the hold-off so that both sides of
  // the comparison are hit, and now and then a jump to an arbitrary time.
  task automatic send_random_request();
    int pick;
    int hold;
    pick = $urandom_range(99);
    hold = int'(cfg_hold_off);
    if (pick < 45) begin
      send_request(OP_TICK, 1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
    end else if (pick < 90) begin
      case ($urandom_range(9))
        0, 1, 2, 3: wall_clock = wall_clock + $urandom_range(3);
        4, 5, 6, 7: wall_clock = wall_clock + $urandom_range(hold + 3, hold / 2);
        8:          wall_clock = wall_clock + $urandom_range(2 * hold + 8);
        default:    wall_clock = $urandom();
      endcase
      send_request(OP_SAMPLE, ($urandom_range(9) < 6), wall_clock, 1'($urandom_range(1)));
    end else if (pick < 98) begin
      send_request(OP_PROGRAM, 1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
    end else begin
      send_request(OP_UNUSED, 1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Alarm gate with the reset settings (level three, ten seconds): a high
  // sample inside the hold-off, a fresh alarm, an alarm while video motion
  // is already active, a low sample that clears the flag, the time stamp
  // wrapping through zero, the unused operation and a repeated request.
  task automatic test_alarm_gate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(OP_SAMPLE, 1'b1, 32'd0, 1'b0);
    send_request(OP_SAMPLE, 1'b1, 32'd11, 1'b0);
    send_request(OP_SAMPLE, 1'b1, 32'd15, 1'b1);
    send_request(OP_SAMPLE, 1'b0, 32'd30, 1'b1);
    send_request(OP_SAMPLE, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_SAMPLE, 1'b1, 32'd5, 1'b0);
    send_request(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_PROGRAM, 1'b0, 32'd0, 1'b0);
  endtask

  // The pulse armed by reset: a request re-armed while the sequence runs,
  // then the level lowered mid-sequence so the remaining thresholds shrink,
  // enough ticks to finish, and finally the sensor switched off so that a
  // sample with no programming pending is ignored and a tick does nothing.
  task automatic test_programming_pulse();
    repeat (4) send_request(OP_TICK, 1'b0, 32'd0, 1'b0);
    send_request(OP_PROGRAM, 1'b1, 32'd0, 1'b1);
    send_request(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1);
    write_register(REG_SENSITIVITY, CFG_DATA_W'(1));
    repeat (12) send_request(OP_TICK, 1'b0, 32'd0, 1'b0);
    write_register(REG_SENSITIVITY, CFG_DATA_W'(0));
    send_request(OP_SAMPLE, 1'b1, 32'hFFFF_0000, 1'b0);
    send_request(OP_TICK, 1'b0, 32'd0, 1'b0);
  endtask

  task automatic run_random_phase(input logic [LEVEL_W-1:0] level,
                                  input logic [HOLD_W-1:0] hold, input int count,
                                  input int send_pct, input int recv_pct);
    write_register(REG_SENSITIVITY, CFG_DATA_W'(level));
    write_register(REG_HOLD_OFF, hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wall_clock = $urandom();
    repeat (count) send_random_request();
  endtask

  // Random traffic over several settings, the extremes among them, first
  // with a slow receiver, then with a slow sender, then at full rate.
  task automatic test_random_traffic();
    run_random_phase(3'd0, 16'd0,     265, 24, 54);
    run_random_phase(3'd7, 16'hFFFF,  265, 24, 54);
    run_random_phase(3'd1, 16'd3,     265, 54, 24);
    run_random_phase(3'd5, 16'd20,    265, 54, 24);
    run_random_phase(3'd2, HOLD_W'($urandom_range(200)), 265, 0, 0);
    run_random_phase(3'd4, 16'd1000,  265, 0, 0);
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so the result register fills and the item side must stall.
  task automatic test_result_backpressure();
    write_register(REG_SENSITIVITY, CFG_DATA_W'(3));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked <= stall_asked + 1;
    repeat (40) send_random_request();
  endtask

  initial begin
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.op            = OP_TICK;
    item_ch.pir_level     = 1'b0;
    item_ch.now_seconds   = '0;
    item_ch.motion_active = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_SENSITIVITY;
    cfg_data              = '0;
    wall_clock            = '0;
    reset_sensor_model();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_alarm_gate();
    test_programming_pulse();
    test_random_traffic();
    test_result_backpressure();
    wait_until_drained();

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pirsag_pkg.sv
hdl/pirsag_if.sv
hdl/pir_sensitivity_pulse_and_alarm_gate_core.sv
bench/pir_sensitivity_pulse_and_alarm_gate_core_tb.sv
